@@ sv/recc_pkg.sv @@
// Shared types and constants for the roadmap edge collision check.
// Register indexes, rectangle packing and reset values; no dependencies.
package recc_pkg;

  localparam int LIM_BITS        = 10;
  localparam int COUNT_BITS      = 2;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 64;
  localparam int RECT_FIELD_BITS = 16;
  // A far edge (x + width) needs one bit more than a field.
  localparam int EDGE_BITS       = RECT_FIELD_BITS + 1;
  // Edge minus coordinate, signed.
  localparam int SIDE_DIFF_BITS  = EDGE_BITS + 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LINK_DISTANCE  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OBSTACLE_COUNT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OBSTACLE_FIRST = 3'd2;

  typedef struct packed {
    logic [RECT_FIELD_BITS-1:0] height;
    logic [RECT_FIELD_BITS-1:0] width;
    logic [RECT_FIELD_BITS-1:0] y;
    logic [RECT_FIELD_BITS-1:0] x;
  } rect_t;

  localparam logic [LIM_BITS-1:0]   LINK_DISTANCE_RESET  = 10'd50;
  localparam logic [COUNT_BITS-1:0] OBSTACLE_COUNT_RESET = 2'd3;

  // Three default obstacles: two tall bars and a bridge between them.
  localparam rect_t RECT_RESET [3] = '{
    '{height: 16'd180, width: 16'd40,  y: 16'd50,  x: 16'd160},
    '{height: 16'd180, width: 16'd40,  y: 16'd50,  x: 16'd330},
    '{height: 16'd40,  width: 16'd130, y: 16'd120, x: 16'd200}
  };

endpackage

@@ sv/roadmap_edge_collision_check.sv @@
// Roadmap edge collision check: range test and segment versus rectangle test.
// Depends on recc_pkg for register indexes, the rectangle type and reset values.
//
//   channel | signals                                   | beat moves
//   --------+-------------------------------------------+--------------------------
//   input   | in_valid, in_ready, from_x/y, to_x/y      | one candidate edge
//   output  | out_valid, out_ready, linked, in_range,   | one verdict per edge
//           | unobstructed                              |
//   config  | cfg_we, cfg_index, cfg_data               | one register write
//
// One beat is accepted every cycle unless an output stall has filled every stage.
// The edge that accepts a beat loads the first of three register stages, and the
// verdict passes them in order: differences and coordinate compares, then the side
// multiplies, then product compares into the output register.
// Reset (rst, synchronous) empties the pipeline and restores the default range
// and obstacles. A stall at the output holds every stage that is full; an empty
// stage still takes a beat, so bubbles close up and nothing is lost or repeated.
module roadmap_edge_collision_check #(
  parameter int OBSTACLE_SLOTS = 3,
  parameter int COORD_BITS     = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [recc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [recc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [COORD_BITS-1:0]                 from_x,
  input  logic [COORD_BITS-1:0]                 from_y,
  input  logic [COORD_BITS-1:0]                 to_x,
  input  logic [COORD_BITS-1:0]                 to_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  linked,
  output logic                                  in_range,
  output logic                                  unobstructed
);

  localparam int CW    = COORD_BITS;
  localparam int DW    = COORD_BITS + 1;              // signed delta
  localparam int EW    = recc_pkg::EDGE_BITS;
  localparam int SW    = recc_pkg::SIDE_DIFF_BITS;
  localparam int PW    = SW + DW;                     // side product
  localparam int LW    = recc_pkg::LIM_BITS;
  localparam int SQW   = 2 * COORD_BITS;
  localparam int CMPW  = (SQW + 1 > 2 * LW) ? SQW + 1 : 2 * LW;

  // Configuration registers.
  logic [LW-1:0]                     link_distance;
  logic [recc_pkg::COUNT_BITS-1:0]   obstacle_count;
  recc_pkg::rect_t                   rect [OBSTACLE_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      link_distance  <= recc_pkg::LINK_DISTANCE_RESET;
      obstacle_count <= recc_pkg::OBSTACLE_COUNT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == recc_pkg::REG_LINK_DISTANCE) begin
        link_distance <= cfg_data[LW-1:0];
      end
      if (cfg_index == recc_pkg::REG_OBSTACLE_COUNT) begin
        obstacle_count <= cfg_data[recc_pkg::COUNT_BITS-1:0];
      end
    end
  end

  // Writes to slots beyond OBSTACLE_SLOTS have nowhere to land and are dropped.
  always_ff @(posedge clk) begin
    for (int i = 0; i < OBSTACLE_SLOTS; i++) begin
      if (rst) begin
        rect[i] <= recc_pkg::RECT_RESET[i];
      end else if (cfg_we &&
                   cfg_index == recc_pkg::REG_OBSTACLE_FIRST +
                                recc_pkg::CFG_INDEX_BITS'(i)) begin
        rect[i] <= cfg_data;
      end
    end
  end

  // Handshake: each stage moves when it is empty or the one after it moves.
  logic v1, v2;
  logic r1, r2, r3;

  assign r3       = !out_valid || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= in_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        out_valid <= v2;
      end
    end
  end

  // Stage 1: deltas, direction normalization and span limits.
  logic signed [DW-1:0] dx, dy;
  logic [EW-1:0]        ax_e, ay_e, lox, hix, loy, hiy;

  assign dx   = DW'(to_x) - DW'(from_x);
  assign dy   = DW'(to_y) - DW'(from_y);
  assign ax_e = EW'(from_x);
  assign ay_e = EW'(from_y);
  assign lox  = (from_x < to_x) ? EW'(from_x) : EW'(to_x);
  assign hix  = (from_x < to_x) ? EW'(to_x)   : EW'(from_x);
  assign loy  = (from_y < to_y) ? EW'(from_y) : EW'(to_y);
  assign hiy  = (from_y < to_y) ? EW'(to_y)   : EW'(from_y);

  logic [CW-1:0]        s1_adx, s1_ady;
  logic signed [DW-1:0] s1_vndy;   // dy with the sign of dx folded in
  logic signed [DW-1:0] s1_hndx;   // dx with the sign of dy folded in

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_adx  <= dx[DW-1] ? CW'(-dx) : CW'(dx);
      s1_ady  <= dy[DW-1] ? CW'(-dy) : CW'(dy);
      s1_vndy <= dx[DW-1] ? -dy : dy;
      s1_hndx <= dy[DW-1] ? -dx : dx;
    end
  end

  // Stage 2: squared lengths for the range test.
  logic [SQW-1:0]  s2_sqx, s2_sqy;
  logic [2*LW-1:0] s2_limsq;

  always_ff @(posedge clk) begin
    if (r2) begin
      s2_sqx   <= s1_adx * s1_adx;
      s2_sqy   <= s1_ady * s1_ady;
      s2_limsq <= link_distance * link_distance;
    end
  end

  logic signed [DW-1:0] adx_s, ady_s;
  assign adx_s = $signed({1'b0, s1_adx});
  assign ady_s = $signed({1'b0, s1_ady});

  logic [OBSTACLE_SLOTS-1:0] slot_hit;
  logic [OBSTACLE_SLOTS-1:0] slot_active;

  for (genvar g = 0; g < OBSTACLE_SLOTS; g++) begin : g_slot
    logic [EW-1:0] x0, x1, y0, y1;

    assign x0 = EW'(rect[g].x);
    assign x1 = EW'(rect[g].x) + EW'(rect[g].width);
    assign y0 = EW'(rect[g].y);
    assign y1 = EW'(rect[g].y) + EW'(rect[g].height);

    // Stage 1 registers: edge offsets and the cheap ordering tests.
    logic signed [SW-1:0] s1_ex0, s1_ex1, s1_ey0, s1_ey1;
    logic s1_hz, s1_vt, s1_vin0, s1_vin1, s1_hin0, s1_hin1;

    always_ff @(posedge clk) begin
      if (r1) begin
        s1_ex0  <= SW'(x0) - SW'(ax_e);
        s1_ex1  <= SW'(x1) - SW'(ax_e);
        s1_ey0  <= SW'(y0) - SW'(ay_e);
        s1_ey1  <= SW'(y1) - SW'(ay_e);
        // A horizontal segment inside the band that steps over a vertical side.
        s1_hz   <= (from_y == to_y) && ay_e > y0 && ay_e < y1 &&
                   ((x0 > lox && x0 < hix) || (x1 > lox && x1 < hix));
        // The same for a vertical segment and the horizontal sides.
        s1_vt   <= (from_x == to_x) && ax_e > x0 && ax_e < x1 &&
                   ((y0 > loy && y0 < hiy) || (y1 > loy && y1 < hiy));
        s1_vin0 <= (from_x != to_x) && x0 >= lox && x0 <= hix;
        s1_vin1 <= (from_x != to_x) && x1 >= lox && x1 <= hix;
        s1_hin0 <= (from_y != to_y) && y0 >= loy && y0 <= hiy;
        s1_hin1 <= (from_y != to_y) && y1 >= loy && y1 <= hiy;
      end
    end

    // Stage 2 registers: the cross products of each side test.
    logic signed [PW-1:0] s2_pv0, s2_pv1, s2_pvl0, s2_pvl1;
    logic signed [PW-1:0] s2_ph0, s2_ph1, s2_phl0, s2_phl1;
    logic s2_hz, s2_vt, s2_vin0, s2_vin1, s2_hin0, s2_hin1;

    always_ff @(posedge clk) begin
      if (r2) begin
        s2_pv0  <= s1_vndy * s1_ex0;
        s2_pv1  <= s1_vndy * s1_ex1;
        s2_pvl0 <= adx_s * s1_ey0;
        s2_pvl1 <= adx_s * s1_ey1;
        s2_ph0  <= s1_hndx * s1_ey0;
        s2_ph1  <= s1_hndx * s1_ey1;
        s2_phl0 <= ady_s * s1_ex0;
        s2_phl1 <= ady_s * s1_ex1;
        s2_hz   <= s1_hz;
        s2_vt   <= s1_vt;
        s2_vin0 <= s1_vin0;
        s2_vin1 <= s1_vin1;
        s2_hin0 <= s1_hin0;
        s2_hin1 <= s1_hin1;
      end
    end

    // The line meets a side strictly inside the opposite span of the rectangle.
    assign slot_hit[g] = s2_hz || s2_vt ||
                         (s2_vin0 && s2_pv0 > s2_pvl0 && s2_pv0 < s2_pvl1) ||
                         (s2_vin1 && s2_pv1 > s2_pvl0 && s2_pv1 < s2_pvl1) ||
                         (s2_hin0 && s2_ph0 > s2_phl0 && s2_ph0 < s2_phl1) ||
                         (s2_hin1 && s2_ph1 > s2_phl0 && s2_ph1 < s2_phl1);
    assign slot_active[g] = recc_pkg::COUNT_BITS'(g) < obstacle_count;
  end

  // Stage 3: final compares into the output register.
  logic [CMPW-1:0] dist_sq;
  logic            in_range_next, unobstructed_next;

  assign dist_sq           = CMPW'(s2_sqx) + CMPW'(s2_sqy);
  assign in_range_next     = dist_sq < CMPW'(s2_limsq);
  assign unobstructed_next = !(|(slot_hit & slot_active));

  always_ff @(posedge clk) begin
    if (r3) begin
      in_range     <= in_range_next;
      unobstructed <= unobstructed_next;
      linked       <= in_range_next && unobstructed_next;
    end
  end

  // With no obstacle in use nothing can block an edge.
  a_no_obstacles_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && obstacle_count == '0) |-> unobstructed)
    else $error("edge reported blocked with no active obstacle");

  // A free output means every stage can move, so the input must be open.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input held while the output is free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result presented right after reset");

endmodule
